FILE: sv/sawa_pkg.sv
// Shared types, codes and helpers for the stop-and-wait ARQ endpoint.
package sawa_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int SEQ_BITS_DEF    = 16;

	localparam logic [15:0] MIN_ADDR = 16'd100;

	// input commands
	localparam logic [1:0] CMD_PACKET = 2'd0;
	localparam logic [1:0] CMD_FRAME  = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	// received frame types (anything else is handled as data)
	localparam logic [1:0] FT_ACK  = 2'd1;
	localparam logic [1:0] FT_NACK = 2'd2;

	// transmitted frame kinds
	localparam logic [1:0] TX_NONE = 2'd0;
	localparam logic [1:0] TX_DATA = 2'd1;
	localparam logic [1:0] TX_ACK  = 2'd2;
	localparam logic [1:0] TX_NACK = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_QFULL     = 3'd1;
	localparam logic [2:0] ST_BAD_DEST  = 3'd2;
	localparam logic [2:0] ST_NOT_OURS  = 3'd3;
	localparam logic [2:0] ST_STALE_ACK = 3'd4;
	localparam logic [2:0] ST_OOO_DROP  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_OWN_ADDR = 2'd0;
	localparam logic [1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_QLIMIT   = 2'd2;

	localparam logic [15:0] OWN_ADDR_RST = 16'd100;
	localparam logic [15:0] TIMEOUT_RST  = 16'd300;
	localparam logic [4:0]  QLIMIT_RST   = 5'd16;

	typedef struct packed {
		logic [15:0] own_addr;
		logic [15:0] timeout_ticks;
		logic [4:0]  queue_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] dest_addr;
		logic [15:0] payload_tag;
		logic [1:0]  frame_type;
		logic [15:0] frame_seq;
		logic [15:0] frame_src;
		logic [15:0] frame_dst;
		logic        bit_error;
	} item_t;

	typedef struct packed {
		logic [1:0]  tx_kind;
		logic [15:0] tx_seq;
		logic [15:0] tx_dst;
		logic [3:0]  tx_hop;
		logic [15:0] tx_tag;
		logic        deliver_valid;
		logic [15:0] deliver_src;
		logic [15:0] deliver_tag;
		logic [2:0]  status;
		logic [4:0]  queue_len;
		logic        waiting;
	} result_t;

	// address modulo 10 via reciprocal multiply; exact for 16-bit inputs
	function automatic logic [3:0] hop_of(input logic [15:0] d);
		logic [31:0] p;
		logic [12:0] q;
		logic [15:0] q10;
		p   = 32'(d) * 32'd52429;
		q   = p[31:19];
		q10 = 16'({q, 3'b000}) + 16'({q, 1'b0});
		return 4'(d - q10);
	endfunction

endpackage

FILE: sv/stop_and_wait_arq_endpoint.sv
// Stop-and-wait ARQ endpoint top level: config registers, input stage, result register.
//
// One event (packet from above, frame from below, timer tick) enters per transaction and
// yields exactly one result transaction. Sustained rate is one event per clock while the
// consumer is ready. The send queue memory is read at the head pointer on the accepting edge
// (synchronous read), the decision is made from the registered event and is loaded into the
// output register once that register can take the result. The output register keeps taking
// results while the consumer is ready, so inputs stall only under output back-pressure.
// Configuration writes are always taken and must only be issued while no event is in flight.
// The send queue needs no clearing after reset; only pushed entries are ever used.
module stop_and_wait_arq_endpoint #(
	parameter int QUEUE_DEPTH = sawa_pkg::QUEUE_DEPTH_DEF,
	parameter int SEQ_BITS    = sawa_pkg::SEQ_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// dest_addr, payload_tag, frame_type, frame_seq, frame_src, frame_dst, bit_error, pad
	input  logic [87:0] s_axis_tdata,
	// command
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tx_kind, tx_seq, tx_dst, tx_hop, tx_tag, deliver_valid, deliver_src, deliver_tag,
	// status, queue_len, waiting
	output logic [95:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sawa_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	cfg_t          cfg_q;
	item_t         item_in, item_s1;
	logic          v_s1, s1_fire, in_acc;
	result_t       res, res_q;
	logic          ov_q;
	logic [31:0]   entry;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, head_d;
	logic [31:0]   mem_wdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_addr      <= OWN_ADDR_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.queue_limit   <= QLIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OWN_ADDR: cfg_q.own_addr      <= cfg_data;
				REG_TIMEOUT:  cfg_q.timeout_ticks <= cfg_data;
				REG_QLIMIT:   cfg_q.queue_limit   <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		item_in.command     = s_axis_tuser;
		item_in.dest_addr   = s_axis_tdata[15:0];
		item_in.payload_tag = s_axis_tdata[31:16];
		item_in.frame_type  = s_axis_tdata[33:32];
		item_in.frame_seq   = s_axis_tdata[49:34];
		item_in.frame_src   = s_axis_tdata[65:50];
		item_in.frame_dst   = s_axis_tdata[81:66];
		item_in.bit_error   = s_axis_tdata[82];
	end

	assign s1_fire       = v_s1 && (!ov_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || s1_fire;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (s1_fire) begin
				v_s1 <= 1'b0;
			end
			if (s1_fire) begin
				ov_q <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_in;
		end
		if (s1_fire) begin
			res_q <= res;
		end
	end

	sawa_qmem #(
		.QD(QUEUE_DEPTH)
	) u_qmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (in_acc),
		.raddr (head_d),
		.rdata (entry)
	);

	sawa_engine #(
		.QD(QUEUE_DEPTH),
		.SB(SEQ_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item_s1),
		.fire      (s1_fire),
		.entry     (entry),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.head_d    (head_d)
	);

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {res_q.waiting, res_q.queue_len, res_q.status, res_q.deliver_tag,
		res_q.deliver_src, res_q.deliver_valid, res_q.tx_tag, res_q.tx_hop, res_q.tx_dst,
		res_q.tx_seq, res_q.tx_kind};

endmodule

FILE: sv/sawa_qmem.sv
// Send queue storage: one write port, one registered read port with write bypass.
module sawa_qmem #(
	parameter int QD = 16,
	localparam int AW = (QD > 1) ? $clog2(QD) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [QD];
	logic [31:0] rdata_q;
	logic [31:0] byp_data_q;
	logic        byp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q    <= mem[raddr];
			byp_q      <= we && (waddr == raddr);
			byp_data_q <= wdata;
		end
	end

	// a push landing on the slot being read wins over the stale array word
	assign rdata = byp_q ? byp_data_q : rdata_q;

endmodule

FILE: sv/sawa_engine.sv
// Protocol state and per-event decision: sequence numbers, timer, queue pointers.
module sawa_engine #(
	parameter int QD = 16,
	parameter int SB = 16,
	localparam int AW = (QD > 1) ? $clog2(QD) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sawa_pkg::cfg_t    cfg,
	input  sawa_pkg::item_t   item,
	input  logic              fire,
	input  logic [31:0]       entry,
	output sawa_pkg::result_t res,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [31:0]       mem_wdata,
	output logic [AW-1:0]     head_d
);
	import sawa_pkg::*;

	localparam int CW = $clog2(QD + 1);

	logic [SB-1:0] seq_q, seq_n, exp_q, exp_n;
	logic          wait_q, wait_n, run_q, run_n;
	logic [15:0]   tmr_q, tmr_n, ldst_q, ldst_n, ltag_q, ltag_n;
	logic [AW-1:0] head_q, head_n;
	logic [CW-1:0] cnt_q, cnt_n;

	logic [CW-1:0] lim;
	logic [AW:0]   slot;
	logic          push, snd, rsnd;
	logic [15:0]   snd_dst, snd_tag, tinc, tlim;
	logic [SB-1:0] fseq, nxt, seq_gap;

	always_comb begin
		seq_n   = seq_q;
		exp_n   = exp_q;
		wait_n  = wait_q;
		run_n   = run_q;
		tmr_n   = tmr_q;
		ldst_n  = ldst_q;
		ltag_n  = ltag_q;
		head_n  = head_q;
		cnt_n   = cnt_q;
		res     = '0;
		push    = 1'b0;
		snd     = 1'b0;
		rsnd    = 1'b0;
		snd_dst = item.dest_addr;
		snd_tag = item.payload_tag;
		fseq    = SB'(item.frame_seq);
		nxt     = exp_q + 1'b1;
		seq_gap = fseq - nxt;
		tinc    = (tmr_q != 16'hFFFF) ? tmr_q + 16'd1 : tmr_q;
		tlim    = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;

		if (32'(cfg.queue_limit) < QD) begin
			lim = CW'(cfg.queue_limit);
		end else begin
			lim = CW'(QD);
		end

		slot = (AW+1)'(head_q) + (AW+1)'(cnt_q);
		if (slot >= (AW+1)'(QD)) begin
			slot = slot - (AW+1)'(QD);
		end

		case (item.command)
			CMD_PACKET: begin
				if (item.dest_addr < MIN_ADDR) begin
					res.status = ST_BAD_DEST;
				end else if (!wait_q) begin
					snd = 1'b1;
				end else if (cnt_q >= lim) begin
					res.status = ST_QFULL;
				end else begin
					push  = 1'b1;
					cnt_n = cnt_q + 1'b1;
				end
			end
			CMD_TICK: begin
				if (run_q) begin
					tmr_n = tinc;
					if (tinc >= tlim) begin
						rsnd = 1'b1;
					end
				end
			end
			CMD_FRAME: begin
				if (item.frame_dst != cfg.own_addr) begin
					res.status = ST_NOT_OURS;
				end else if (item.frame_type == FT_NACK) begin
					rsnd = wait_q;
				end else if (item.frame_type == FT_ACK) begin
					if (fseq == seq_q) begin
						if (cnt_q != '0) begin
							snd     = 1'b1;
							snd_dst = entry[31:16];
							snd_tag = entry[15:0];
							cnt_n   = cnt_q - 1'b1;
							head_n  = (32'(head_q) == QD - 1) ? '0 : head_q + 1'b1;
						end else begin
							wait_n = 1'b0;
							run_n  = 1'b0;
							tmr_n  = '0;
						end
					end else begin
						res.status = ST_STALE_ACK;
					end
				end else if (item.bit_error) begin
					res.tx_kind = TX_NACK;
					res.tx_seq  = item.frame_seq;
					res.tx_dst  = item.frame_src;
				end else if (seq_gap == '0) begin
					exp_n             = nxt;
					res.tx_kind       = TX_ACK;
					res.tx_seq        = 16'(nxt);
					res.tx_dst        = item.frame_src;
					res.deliver_valid = 1'b1;
					res.deliver_src   = item.frame_src;
					res.deliver_tag   = item.payload_tag;
				end else if (seq_gap[SB-1]) begin
					// older frame: cumulative ACK of what we already hold
					res.tx_kind = TX_ACK;
					res.tx_seq  = 16'(exp_q);
					res.tx_dst  = item.frame_src;
				end else begin
					res.status = ST_OOO_DROP;
				end
			end
			default: begin
			end
		endcase

		if (snd) begin
			seq_n       = seq_q + 1'b1;
			ldst_n      = snd_dst;
			ltag_n      = snd_tag;
			res.tx_kind = TX_DATA;
			res.tx_seq  = 16'(seq_n);
			res.tx_dst  = snd_dst;
			res.tx_tag  = snd_tag;
		end else if (rsnd) begin
			res.tx_kind = TX_DATA;
			res.tx_seq  = 16'(seq_q);
			res.tx_dst  = ldst_q;
			res.tx_tag  = ltag_q;
		end
		if (snd || rsnd) begin
			wait_n = 1'b1;
			run_n  = 1'b1;
			tmr_n  = '0;
		end

		res.tx_hop    = hop_of(res.tx_dst);
		res.queue_len = 5'(cnt_n);
		res.waiting   = wait_n;
	end

	assign mem_we    = fire && push;
	assign mem_waddr = AW'(slot);
	assign mem_wdata = {item.dest_addr, item.payload_tag};
	assign head_d    = fire ? head_n : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= '0;
			exp_q  <= '0;
			wait_q <= 1'b0;
			run_q  <= 1'b0;
			tmr_q  <= '0;
			ldst_q <= '0;
			ltag_q <= '0;
			head_q <= '0;
			cnt_q  <= '0;
		end else if (fire) begin
			seq_q  <= seq_n;
			exp_q  <= exp_n;
			wait_q <= wait_n;
			run_q  <= run_n;
			tmr_q  <= tmr_n;
			ldst_q <= ldst_n;
			ltag_q <= ltag_n;
			head_q <= head_n;
			cnt_q  <= cnt_n;
		end
	end

	a_timer_needs_wait: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> wait_q)
		else $error("timer running while not awaiting an ACK");

	a_idle_queue_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!wait_q |-> cnt_q == '0)
		else $error("packets queued while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= QD)
		else $error("queue count above depth");

	a_data_arms_timer: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.tx_kind == TX_DATA |=> wait_q && run_q && tmr_q == '0)
		else $error("data frame sent without arming the timer");

endmodule
